// ===== rtl/core/max_heap_priority_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top_macros
// Assertion helpers for the heap queue, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define MHPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mhpq: assertion failed");

// next-cycle implication
`define MHPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mhpq: assertion failed");

`endif

// ===== rtl/core/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and fixed field widths of the heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int KEY_W     = 16;
    localparam int CNT_OUT_W = 11;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] count;
        logic                 ok;
        logic [KEY_W-1:0]     max_key;
    } res_t;

endpackage

// ===== rtl/core/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// mhpq_ram
// Heap array: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [DATA_W-1:0]        rdata0,
    output logic [DATA_W-1:0]        rdata1
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== rtl/core/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for insert (sift up) and extract (sift down) over the heap array.
// ----------------------------------------------------------------------------
module mhpq_ctrl #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_func,
    input  logic [mhpq_pkg::KEY_W-1:0]  in_key,
    output logic                        res_valid,
    input  logic                        res_ready,
    output mhpq_pkg::res_t              res,
    output logic                        mem_we,
    output logic [$clog2(CAPACITY)-1:0] mem_waddr,
    output logic [KEY_BITS-1:0]         mem_wdata,
    output logic [$clog2(CAPACITY)-1:0] mem_raddr0,
    output logic [$clog2(CAPACITY)-1:0] mem_raddr1,
    input  logic [KEY_BITS-1:0]         mem_rdata0,
    input  logic [KEY_BITS-1:0]         mem_rdata1
);
    import mhpq_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_UP_FIN = 4'd3;
    localparam logic [3:0] S_EX_LD  = 4'd4;
    localparam logic [3:0] S_DN_CMP = 4'd5;
    localparam logic [3:0] S_RESP   = 4'd6;

    logic [3:0]          state_reg, state_next;
    logic                op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] max_reg, max_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ok_reg, ok_next;

    logic [KEY_BITS+KEY_W-1:0]   key_ext;
    logic [KEY_BITS+KEY_W-1:0]   max_ext;
    logic [CNT_W+CNT_OUT_W-1:0]  cnt_ext;
    logic [CNT_W-1:0]            cnt_m1;
    logic [ADDR_W-1:0]           par_cnt;
    logic [ADDR_W-1:0]           par;
    logic [ADDR_W-1:0]           gpar;
    logic [ADDR_W+1:0]           lc, rc, cnt_x, cl, cr;
    logic                        l_ok, r_ok, take_l, take_r;
    logic [KEY_BITS-1:0]         best_val, child_val;
    logic [ADDR_W-1:0]           child;

    assign key_ext = {{KEY_BITS{1'b0}}, in_key};
    assign max_ext = {{KEY_W{1'b0}}, max_reg};
    assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_reg};

    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign par_cnt = ADDR_W'(cnt_m1 >> 1);
    assign par     = (pos_reg - ADDR_W'(1)) >> 1;
    assign gpar    = (par - ADDR_W'(1)) >> 1;

    assign lc    = {1'b0, pos_reg, 1'b1};
    assign rc    = lc + (ADDR_W+2)'(1);
    assign cnt_x = (ADDR_W+2)'(cnt_reg);
    assign l_ok  = lc < cnt_x;
    assign r_ok  = rc < cnt_x;

    always_comb begin
        take_l    = l_ok && (mem_rdata0 >= key_reg);
        best_val  = take_l ? mem_rdata0 : key_reg;
        take_r    = r_ok && (mem_rdata1 >= best_val);
        child     = take_r ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
        child_val = take_r ? mem_rdata1 : mem_rdata0;
    end

    assign cl = {1'b0, child, 1'b1};
    assign cr = cl + (ADDR_W+2)'(1);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        max_next   = max_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        ok_next    = ok_reg;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = key_reg;
        mem_raddr0 = par;
        mem_raddr1 = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next    = in_func;
                    key_next   = key_ext[KEY_BITS-1:0];
                    state_next = S_START;
                end
            end
            S_START: begin
                max_next = '0;
                ok_next  = 1'b0;
                if (op_reg == OP_INSERT) begin
                    if (cnt_reg == CNT_W'(CAPACITY)) begin
                        state_next = S_RESP;
                    end else begin
                        ok_next  = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                        pos_next = cnt_reg[ADDR_W-1:0];
                        if (cnt_reg == '0) begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            state_next = S_RESP;
                        end else begin
                            mem_raddr0 = par_cnt;
                            state_next = S_UP_CMP;
                        end
                    end
                end else begin
                    if (cnt_reg != '0) begin
                        ok_next    = 1'b1;
                        cnt_next   = cnt_m1;
                        mem_raddr0 = '0;
                        mem_raddr1 = cnt_m1[ADDR_W-1:0];
                        state_next = S_EX_LD;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (mem_rdata0 < key_reg) begin
                    mem_wdata = mem_rdata0;
                    pos_next  = par;
                    if (par == '0) begin
                        state_next = S_UP_FIN;
                    end else begin
                        mem_raddr0 = gpar;
                    end
                end else begin
                    state_next = S_RESP;
                end
            end
            S_UP_FIN: begin
                mem_we     = 1'b1;
                state_next = S_RESP;
            end
            S_EX_LD: begin
                max_next = mem_rdata0;
                key_next = mem_rdata1;
                pos_next = '0;
                if (cnt_reg == '0) begin
                    state_next = S_RESP;
                end else begin
                    mem_raddr0 = ADDR_W'(1);
                    mem_raddr1 = ADDR_W'(2);
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (take_l || take_r) begin
                    mem_wdata  = child_val;
                    pos_next   = child;
                    mem_raddr0 = cl[ADDR_W-1:0];
                    mem_raddr1 = cr[ADDR_W-1:0];
                end else begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.max_key = max_ext[KEY_W-1:0];
    assign res.ok      = ok_reg;
    assign res.count   = cnt_ext[CNT_OUT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        op_reg  <= op_next;
        key_reg <= key_next;
        max_reg <= max_next;
        pos_reg <= pos_next;
        ok_reg  <= ok_next;
    end

endmodule

// ===== rtl/core/mhpq_obuf.sv =====
// ----------------------------------------------------------------------------
// mhpq_obuf
// One-entry result register between the sequencer and the master channel.
// ----------------------------------------------------------------------------
module mhpq_obuf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  mhpq_pkg::res_t in_res,
    output logic           out_valid,
    input  logic           out_ready,
    output mhpq_pkg::res_t out_res
);
    import mhpq_pkg::*;

    logic full_reg, full_next;
    res_t data_reg;

    assign in_ready  = !full_reg || out_ready;
    assign out_valid = full_reg;
    assign out_res   = data_reg;

    always_comb begin
        full_next = full_reg;
        if (in_valid && in_ready) begin
            full_next = 1'b1;
        end else if (out_ready) begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
        if (in_valid && in_ready) begin
            data_reg <= in_res;
        end
    end

endmodule

// ===== rtl/core/max_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top
// Binary max-heap priority queue held in a dual-read synchronous RAM.
// ----------------------------------------------------------------------------
// Each slave request is an insert (func 0) or an extract-maximum (func 1);
// each gives exactly one master result: the extracted key (0 on insert or
// error), an ok flag and the entry count after the step. Extract from an
// empty heap or insert into a full one returns ok 0 and leaves the heap alone.
// One request is in work at a time. An insert sifts the new key up level
// by level; an extract reads the root and the last entry, then sifts down
// level by level. An insert into an empty or a full heap, an extract from
// an empty heap and one that takes the last entry need no sifting. Each
// level is one RAM read-compare-write. s_tready is high again in the
// cycle after the result moves to the output register, so a new request
// is taken only once the last one has left the sequencer.
// Reset clears the state and the count only; RAM contents need no
// clearing, so requests are accepted as soon as reset is released.
// A stalled receiver holds the result in the output register; one
// further request is still worked and its result waits in the sequencer
// until the register frees.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_top_macros.svh"

module max_heap_priority_queue_top #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mhpq_pkg::S_DATA_W-1:0]  s_tdata,  // func, key[15:0], pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mhpq_pkg::M_DATA_W-1:0]  m_tdata   // max_key[15:0], ok, count[10:0], pad
);
    import mhpq_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    logic                res_valid, res_ready;
    res_t                res, out_res;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr0, mem_raddr1;
    logic [KEY_BITS-1:0] mem_wdata, mem_rdata0, mem_rdata1;

    mhpq_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (KEY_BITS)
    ) u_ram (
        .aclk   (aclk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (mem_rdata0),
        .rdata1 (mem_rdata1)
    );

    mhpq_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tdata[0]),
        .in_key     (s_tdata[KEY_W:1]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr0 (mem_raddr0),
        .mem_raddr1 (mem_raddr1),
        .mem_rdata0 (mem_rdata0),
        .mem_rdata1 (mem_rdata1)
    );

    mhpq_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {{(M_DATA_W - CNT_OUT_W - 1 - KEY_W){1'b0}},
                      out_res.count, out_res.ok, out_res.max_key};

    `MHPQ_ASSERT_NXT(a_one_request_in_work, s_tvalid && s_tready, !s_tready)
    `MHPQ_ASSERT_IMP(a_error_key_zero, m_tvalid && !out_res.ok, out_res.max_key == '0)
    `MHPQ_ASSERT_IMP(a_result_held_in_work, res_valid && !res_ready, m_tvalid && !s_tready)

endmodule
